// ===== hw/rtl/deq_pkg.sv =====
// deq_pkg: shared types, sizes and codes of the double-ended queue core
// used by deq_cell, double_ended_queue_core and deq_checker
// no dependencies

package deq_pkg;

    // number of elements the row of cells can hold
    localparam int DEPTH = 16;

    // widths derived from the depth
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // item layout on the streams
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int IN_BITS   = FUNC_W + DATA_W;
    localparam int OUT_BITS  = DATA_W + STATUS_W + CNT_W;
    localparam int IN_TDW    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDW   = ((OUT_BITS + 7) / 8) * 8;

    // operation codes carried by an input item
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_FRONT = 3'd0,
        FUNC_PUSH_BACK  = 3'd1,
        FUNC_POP_FRONT  = 3'd2,
        FUNC_POP_BACK   = 3'd3,
        FUNC_PEEK_FRONT = 3'd4,
        FUNC_PEEK_BACK  = 3'd5,
        FUNC_CLEAR      = 3'd6
    } func_t;

    // status codes of a result item
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // what every cell of the row does when clocked
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_SHIFT_IN   = 2'd1,
        CELL_SHIFT_OUT  = 2'd2,
        CELL_WRITE_BACK = 2'd3
    } cell_op_t;

    // control broadcast from the top level to the row of cells
    typedef struct packed {
        cell_op_t         op;
        logic [CNT_W-1:0] count;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/deq_cell.sv =====
// deq_cell: one storage cell of the deque row, holds one element
// shifts toward the back on a front push, toward the front on a front pop
// depends on deq_pkg

module deq_cell (
    input  logic                        aclk,
    input  deq_pkg::cell_ctrl_t         ctrl,
    input  logic [deq_pkg::IDX_W-1:0]   cell_idx,
    input  logic [deq_pkg::DATA_W-1:0]  left_data,
    input  logic [deq_pkg::DATA_W-1:0]  right_data,
    input  logic [deq_pkg::DATA_W-1:0]  push_value,
    output logic [deq_pkg::DATA_W-1:0]  data_out,
    output logic [deq_pkg::DATA_W-1:0]  back_tap
);

    logic [deq_pkg::DATA_W-1:0] data_reg;
    logic [deq_pkg::DATA_W-1:0] data_next;
    logic [deq_pkg::CNT_W-1:0]  idx_ext;
    logic                       is_back;
    logic                       is_tail;

    assign idx_ext = deq_pkg::CNT_W'(cell_idx);
    // this cell holds the back element
    assign is_back = (idx_ext == ctrl.count - deq_pkg::CNT_W'(1));
    // this cell is the first free slot behind the back element
    assign is_tail = (idx_ext == ctrl.count);

    // next content from the neighbors or the pushed item
    always_comb begin
        data_next = data_reg;
        unique case (ctrl.op)
            deq_pkg::CELL_HOLD:       data_next = data_reg;
            deq_pkg::CELL_SHIFT_IN:   data_next = left_data;
            deq_pkg::CELL_SHIFT_OUT:  data_next = right_data;
            deq_pkg::CELL_WRITE_BACK: data_next = is_tail ? push_value : data_reg;
            default:                  data_next = data_reg;
        endcase
    end

    // element storage, no reset needed
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    assign back_tap = is_back ? data_reg : '0;

endmodule

// ===== hw/rtl/double_ended_queue_core.sv =====
// double_ended_queue_core: bounded deque built as a row of deq_cell elements
// a result item appears on the cycle after its input item is accepted
// throughput: one item per cycle; every cell of the row updates in the same cycle
// the result register holds one item, so input stalls only while it is not taken
// reset: synchronous active-low aresetn empties the deque and drops the result
// depends on deq_pkg and deq_cell

module double_ended_queue_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] func, [34:3] value, upper bits zero
    input  logic [deq_pkg::IN_TDW-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] read_value, [33:32] status, [38:34] occupancy, upper bits zero
    output logic [deq_pkg::OUT_TDW-1:0]   m_tdata
);

    localparam int D = deq_pkg::DEPTH;

    logic [deq_pkg::CNT_W-1:0]    count_reg;
    logic [deq_pkg::CNT_W-1:0]    count_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [deq_pkg::OUT_BITS-1:0] m_data_reg;
    logic [deq_pkg::OUT_BITS-1:0] m_data_next;

    logic                         accept;
    logic [deq_pkg::FUNC_W-1:0]   func;
    logic [deq_pkg::DATA_W-1:0]   value;
    logic                         full;
    logic                         empty;
    deq_pkg::cell_ctrl_t          ctrl;
    logic [deq_pkg::DATA_W-1:0]   rd_value;
    deq_pkg::status_t             status;
    logic [deq_pkg::DATA_W-1:0]   back_value;

    logic [deq_pkg::DATA_W-1:0]   cell_data [D];
    logic [deq_pkg::DATA_W-1:0]   cell_back [D];
    logic [deq_pkg::DATA_W-1:0]   cell_left [D];
    logic [deq_pkg::DATA_W-1:0]   cell_right[D];

    assign func   = s_tdata[deq_pkg::FUNC_W-1:0];
    assign value  = s_tdata[deq_pkg::IN_BITS-1:deq_pkg::FUNC_W];
    assign accept = s_tvalid && s_tready;
    assign full   = (count_reg == deq_pkg::CNT_W'(D));
    assign empty  = (count_reg == '0);

    // input side frees as soon as the result register drains
    assign s_tready = !m_valid_reg || m_tready;

    // back element picked from the cell whose tap is live
    always_comb begin
        back_value = '0;
        for (int i = 0; i < D; i++) begin
            back_value = back_value | cell_back[i];
        end
    end

    // operation decode: cell command, new count, result fields
    always_comb begin
        ctrl.op    = deq_pkg::CELL_HOLD;
        ctrl.count = count_reg;
        count_next = count_reg;
        rd_value   = '0;
        status     = deq_pkg::STATUS_OK;
        if (accept) begin
            unique case (func)
                deq_pkg::FUNC_PUSH_FRONT: begin
                    if (full) begin
                        status = deq_pkg::STATUS_FULL;
                    end else begin
                        ctrl.op    = deq_pkg::CELL_SHIFT_IN;
                        count_next = count_reg + deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::FUNC_PUSH_BACK: begin
                    if (full) begin
                        status = deq_pkg::STATUS_FULL;
                    end else begin
                        ctrl.op    = deq_pkg::CELL_WRITE_BACK;
                        count_next = count_reg + deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::FUNC_POP_FRONT: begin
                    if (empty) begin
                        status = deq_pkg::STATUS_EMPTY;
                    end else begin
                        rd_value   = cell_data[0];
                        ctrl.op    = deq_pkg::CELL_SHIFT_OUT;
                        count_next = count_reg - deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::FUNC_POP_BACK: begin
                    if (empty) begin
                        status = deq_pkg::STATUS_EMPTY;
                    end else begin
                        rd_value   = back_value;
                        count_next = count_reg - deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::FUNC_PEEK_FRONT: begin
                    if (empty) begin
                        status = deq_pkg::STATUS_EMPTY;
                    end else begin
                        rd_value = cell_data[0];
                    end
                end
                deq_pkg::FUNC_PEEK_BACK: begin
                    if (empty) begin
                        status = deq_pkg::STATUS_EMPTY;
                    end else begin
                        rd_value = back_value;
                    end
                end
                deq_pkg::FUNC_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // result register next value
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = {count_next, status, rd_value};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = deq_pkg::OUT_TDW'(m_data_reg);

    // row of cells, front at cell zero
    for (genvar i = 0; i < D; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign cell_left[i] = value;
        end else begin : g_mid
            assign cell_left[i] = cell_data[i-1];
        end
        if (i == D - 1) begin : g_last
            assign cell_right[i] = '0;
        end else begin : g_inner
            assign cell_right[i] = cell_data[i+1];
        end

        deq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cell_idx   (deq_pkg::IDX_W'(i)),
            .left_data  (cell_left[i]),
            .right_data (cell_right[i]),
            .push_value (value),
            .data_out   (cell_data[i]),
            .back_tap   (cell_back[i])
        );
    end

endmodule

// ===== hw/rtl/deq_checker.sv =====
// deq_checker: port-level checks of double_ended_queue_core over time
// bound to the top level below; depends on deq_pkg

module deq_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [deq_pkg::IN_TDW-1:0]    s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [deq_pkg::OUT_TDW-1:0]   m_tdata
);

    localparam int OCC_LO = deq_pkg::DATA_W + deq_pkg::STATUS_W;

    logic [deq_pkg::CNT_W-1:0]    occ;
    logic [deq_pkg::STATUS_W-1:0] st;
    logic [deq_pkg::FUNC_W-1:0]   in_func;

    assign occ     = m_tdata[deq_pkg::OUT_BITS-1:OCC_LO];
    assign st      = m_tdata[OCC_LO-1:deq_pkg::DATA_W];
    assign in_func = s_tdata[deq_pkg::FUNC_W-1:0];

    // no result survives reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // occupancy never exceeds the depth
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> occ <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
        else $error("occupancy above depth");

    // every accepted item yields its result on the next cycle
    a_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("result missing after accepted item");

    // a clear always reports an empty deque and ok status
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && in_func == deq_pkg::FUNC_CLEAR |=>
        occ == '0 && st == deq_pkg::STATUS_OK)
        else $error("clear result wrong");

    // a stalled result holds its item
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
